[src/bfp_pkg.sv]
// Package for the two-probe Bloom filter: store geometry and action codes.
// Used by the bit RAM instance and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bfp_pkg;

    // Filter holds 2^FILTER_BITS_LOG2 bits (allowed range 8 to 27).
    localparam int FILTER_BITS_LOG2 = 16;

    // The bit store is organized as rows of 2^ROW_BITS_LOG2 bits.
    localparam int ROW_BITS_LOG2 = 6;
    localparam int ROW_BITS      = 1 << ROW_BITS_LOG2;
    localparam int ROW_ADDR_W    = FILTER_BITS_LOG2 - ROW_BITS_LOG2;

    // Width of one probe index.
    localparam int PROBE_W = FILTER_BITS_LOG2;

    // Width of one half of the key hash.
    localparam int HASH_HALF_W = 32;
    localparam int HASH_W      = 2 * HASH_HALF_W;

    // Action codes carried with each request.
    localparam int ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TEST  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Row address of a probe index.
    function automatic logic [ROW_ADDR_W-1:0] row_of(input logic [PROBE_W-1:0] probe);
        row_of = probe[PROBE_W-1:ROW_BITS_LOG2];
    endfunction

    // Bit position of a probe index within its row.
    function automatic logic [ROW_BITS_LOG2-1:0] col_of(input logic [PROBE_W-1:0] probe);
        col_of = probe[ROW_BITS_LOG2-1:0];
    endfunction

endpackage

`default_nettype wire

[src/bfp_bit_ram.sv]
// Single-port synchronous RAM holding the filter bit store, one row per word.
// Read data is registered; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bfp_bit_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    // One access per cycle: write, or read with registered data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

[src/bloom_filter_two_probe_core.sv]
// Top level of the two-probe Bloom filter: request sequencer and output register.
// Depends on bfp_pkg and instantiates bfp_bit_ram for the bit store.
`timescale 1ns / 1ps
`default_nettype none

// Two-probe Bloom filter over a store of 2^16 bits kept in one single-port RAM
// of 64-bit rows. Probe one is the upper hash half and probe two the lower half,
// each taken modulo the filter size. An add reads and rewrites each probe row in
// turn and a test only reads them, since the single RAM port allows one access
// per cycle. A clear request, and reset itself, sweep every row with zeros, one
// row per cycle, during which no request is accepted. An undefined action leaves
// the store alone. Every request yields exactly one result; present is 1 only
// for a test whose two probe bits are both set. A new request may be accepted
// while the last result still waits in the output register.
module bloom_filter_two_probe_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bfp_pkg::ACTION_W-1:0]  action,
    input  wire logic [bfp_pkg::HASH_W-1:0]    hash_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               present
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD1  = 3'd1;
    localparam logic [2:0] S_RD2   = 3'd2;
    localparam logic [2:0] S_MOD2  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0]                          state_reg, state_next;
    logic [bfp_pkg::ACTION_W-1:0]        act_reg, act_next;
    logic [bfp_pkg::PROBE_W-1:0]         probe1_reg, probe1_next;
    logic [bfp_pkg::PROBE_W-1:0]         probe2_reg, probe2_next;
    logic                                hit_reg, hit_next;
    logic [bfp_pkg::ROW_ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                                clr_resp_reg, clr_resp_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                present_reg, present_next;

    logic                                mem_en;
    logic                                mem_we;
    logic [bfp_pkg::ROW_ADDR_W-1:0]      mem_addr;
    logic [bfp_pkg::ROW_BITS-1:0]        mem_wdata;
    logic [bfp_pkg::ROW_BITS-1:0]        mem_rdata;

    logic                                in_fire;
    logic                                out_free;
    logic [bfp_pkg::PROBE_W-1:0]         in_probe1;
    logic [bfp_pkg::PROBE_W-1:0]         in_probe2;

    bfp_bit_ram #(
        .ADDR_W (bfp_pkg::ROW_ADDR_W),
        .DATA_W (bfp_pkg::ROW_BITS)
    ) u_bit_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Handshake and probe extraction from the incoming hash.
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_probe1 = hash_value[bfp_pkg::HASH_HALF_W +: bfp_pkg::PROBE_W];
    assign in_probe2 = hash_value[bfp_pkg::PROBE_W-1:0];

    assign out_valid = out_valid_reg;
    assign present   = present_reg;

    // Sequencer: drives the RAM port and walks each request through its steps.
    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        probe1_next    = probe1_reg;
        probe2_next    = probe2_reg;
        hit_next       = hit_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_resp_next  = clr_resp_reg;
        out_valid_next = out_valid_reg;
        present_next   = present_reg;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = bfp_pkg::row_of(probe1_reg);
        mem_wdata      = mem_rdata;

        // The waiting result leaves when taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    act_next    = action;
                    probe1_next = in_probe1;
                    probe2_next = in_probe2;
                    hit_next    = 1'b0;
                    if (action == bfp_pkg::ACT_ADD || action == bfp_pkg::ACT_TEST)
                    begin
                        // Start the read of the first probe row right away.
                        mem_en     = 1'b1;
                        mem_addr   = bfp_pkg::row_of(in_probe1);
                        state_next = S_MOD1;
                    end
                    else if (action == bfp_pkg::ACT_CLEAR)
                    begin
                        clr_cnt_next  = '0;
                        clr_resp_next = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_MOD1:
            begin
                // First row is back: set the bit for an add, sample it for a test.
                hit_next = mem_rdata[bfp_pkg::col_of(probe1_reg)];
                if (act_reg == bfp_pkg::ACT_ADD)
                begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = bfp_pkg::row_of(probe1_reg);
                    mem_wdata = mem_rdata
                              | (bfp_pkg::ROW_BITS'(1) << bfp_pkg::col_of(probe1_reg));
                end
                state_next = S_RD2;
            end

            S_RD2:
            begin
                // The first write has landed, so a shared row reads back updated.
                mem_en     = 1'b1;
                mem_addr   = bfp_pkg::row_of(probe2_reg);
                state_next = S_MOD2;
            end

            S_MOD2:
            begin
                hit_next = hit_reg && mem_rdata[bfp_pkg::col_of(probe2_reg)];
                if (act_reg == bfp_pkg::ACT_ADD)
                begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = bfp_pkg::row_of(probe2_reg);
                    mem_wdata = mem_rdata
                              | (bfp_pkg::ROW_BITS'(1) << bfp_pkg::col_of(probe2_reg));
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    present_next   = (act_reg == bfp_pkg::ACT_TEST) && hit_reg;
                    state_next     = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                // Zero one row per cycle across the whole store.
                mem_en       = 1'b1;
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next    = clr_resp_reg ? S_DONE : S_IDLE;
                    clr_resp_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts with a clearing sweep of the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        probe1_reg  <= probe1_next;
        probe2_reg  <= probe2_next;
        hit_reg     <= hit_next;
        present_reg <= present_next;
    end

endmodule

`default_nettype wire

[tb/bloom_filter_two_probe_core_test.sv]
// Self-checking testbench for the two-probe Bloom filter core.
// It depends on bfp_pkg and bloom_filter_two_probe_core. A shadow bit store
// predicts each present flag, and randomly stalled handshakes exercise the core.
`timescale 1ns / 1ps

module bloom_filter_two_probe_core_test;

    import bfp_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 2'd3;

    localparam int RANDOM_REQUESTS = 400;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_AT     = 120;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int KEY_POOL_DEPTH  = 64;

    // Shadow copy of the filter bits and the queue of present flags still owed.
    class bloom_scoreboard;
        bit filter_bits [0:(1 << FILTER_BITS_LOG2) - 1];
        bit owed_present [$];
        int mismatches;

        function new();
            clear_bits();
            mismatches = 0;
        endfunction

        function void clear_bits();
            foreach (filter_bits[i])
                filter_bits[i] = 1'b0;
        endfunction

        // Apply an accepted request to the shadow store and queue its flag.
        function void note_request(logic [ACTION_W-1:0] act, logic [HASH_W-1:0] hash);
            logic [PROBE_W-1:0] probe_one;
            logic [PROBE_W-1:0] probe_two;
            bit hit;
            probe_one = hash[HASH_HALF_W +: PROBE_W];
            probe_two = hash[PROBE_W-1:0];
            hit = 1'b0;
            case (act)
                ACT_ADD:
                begin
                    filter_bits[probe_one] = 1'b1;
                    filter_bits[probe_two] = 1'b1;
                end
                ACT_TEST:  hit = filter_bits[probe_one] && filter_bits[probe_two];
                ACT_CLEAR: clear_bits();
                default:   ;
            endcase
            owed_present.push_back(hit);
        endfunction

        // Compare one accepted result with the oldest owed flag.
        function void check_present(logic actual);
            bit wanted;
            if (owed_present.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result: present=%b with no request pending", actual);
                return;
            end
            wanted = owed_present.pop_front();
            if (actual !== wanted)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Present mismatch: expected %b, got %b", wanted, actual);
            end
        endfunction

        function int pending();
            return owed_present.size();
        endfunction
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [ACTION_W-1:0] action     = ACT_ADD;
    logic [HASH_W-1:0]   hash_value = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic                present;

    bloom_scoreboard   filter_model;
    bit                sender_eager   = 1'b0;
    bit                receiver_eager = 1'b0;
    int                cycle_count    = 0;
    logic [HASH_W-1:0] added_keys [$];

    bloom_filter_two_probe_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .hash_value (hash_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .present    (present)
    );

    always #4 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[bloom_filter_two_probe_core] ERROR");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until it is accepted.
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [HASH_W-1:0] hash);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        hash_value <= hash;
        do
            @(posedge clk);
        while (!in_ready);
        filter_model.note_request(act, hash);
        if (act == ACT_ADD)
        begin
            added_keys.push_back(hash);
            if (added_keys.size() > KEY_POOL_DEPTH)
                void'(added_keys.pop_front());
        end
    endtask

    // Full-width random hash; sometimes both probes are squeezed into a small
    // window so that keys collide and tests find bits set by other keys.
    function automatic logic [HASH_W-1:0] random_hash();
        logic [HASH_W-1:0] h;
        h = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
        begin
            h[HASH_HALF_W + 6 +: PROBE_W - 6] = '0;
            h[6 +: PROBE_W - 6] = '0;
        end
        return h;
    endfunction

    // Test keys: mostly keys already added, some mixing halves of two added
    // keys, the rest fresh.
    function automatic logic [HASH_W-1:0] pick_test_key();
        logic [HASH_W-1:0] first_key;
        logic [HASH_W-1:0] second_key;
        int pick;
        pick = $urandom_range(0, 3);
        if (added_keys.size() == 0 || pick == 3)
            return random_hash();
        first_key  = added_keys[$urandom_range(0, added_keys.size() - 1)];
        second_key = added_keys[$urandom_range(0, added_keys.size() - 1)];
        if (pick == 2)
            return {first_key[HASH_W-1:HASH_HALF_W], second_key[HASH_HALF_W-1:0]};
        return first_key;
    endfunction

    // Result side: random stalls, eager stretches, and one long hold-off.
    initial
    begin
        int results;
        int stall;
        results = 0;
        wait (rst_n);
        forever
        begin
            if (results % 40 == 0)
                receiver_eager = ($urandom_range(0, 2) == 0);
            @(negedge clk);
            if (results == HOLD_OFF_AT)
                stall = HOLD_OFF_CYCLES;
            else
                stall = receiver_eager ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            filter_model.check_present(present);
            results++;
        end
    end

    // Request side: reset, directed cases, random traffic, then drain.
    initial
    begin
        int roll;
        filter_model = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty filter after the reset sweep.
        send_request(ACT_TEST, 64'h0);
        send_request(ACT_TEST, 64'hFFFF_FFFF_FFFF_FFFF);
        // Both probes equal, at the top and the bottom of the store.
        send_request(ACT_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_TEST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_ADD, 64'h0);
        send_request(ACT_TEST, 64'h0);
        // Distinct probes; hash bits above the filter size are ignored.
        send_request(ACT_ADD, 64'h0000_1234_0000_5678);
        send_request(ACT_TEST, 64'hABCD_1234_FFFF_5678);
        send_request(ACT_TEST, 64'h0000_1234_0000_5679);
        send_request(ACT_TEST, 64'h0000_5678_0000_1234);
        // An undefined action must not touch the store.
        send_request(ACT_UNDEFINED, 64'h0000_0042_0000_0042);
        send_request(ACT_TEST, 64'h0000_0042_0000_0042);
        // Clear wipes everything added so far.
        send_request(ACT_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_TEST, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ACT_TEST, 64'h0000_1234_0000_5678);
        send_request(ACT_ADD, 64'h5555_5555_5555_5555);
        send_request(ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(ACT_TEST, 64'h5555_5555_AAAA_AAAA);
        send_request(ACT_TEST, 64'h5555_5555_0000_0000);

        // Random traffic with occasional back-to-back stretches.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 50 == 0)
                sender_eager = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 45)
                send_request(ACT_ADD, random_hash());
            else if (roll < 90)
                send_request(ACT_TEST, pick_test_key());
            else if (roll < 93)
                send_request(ACT_CLEAR, random_hash());
            else
                send_request(ACT_UNDEFINED, random_hash());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (filter_model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (filter_model.mismatches == 0 && filter_model.pending() == 0)
            $display("[bloom_filter_two_probe_core] OK");
        else
            $display("[bloom_filter_two_probe_core] ERROR");
        $finish;
    end

endmodule

[sim.f]
src/bfp_pkg.sv
src/bfp_bit_ram.sv
src/bloom_filter_two_probe_core.sv
tb/bloom_filter_two_probe_core_test.sv
